// ----- rtl/angle_bias_kalman_filter_assert.svh -----
// Assertion macros shared by the checker of the angle and bias Kalman filter.
// Each macro expects the signals aclk and aresetn to be visible where it is used.
`ifndef ANGLE_BIAS_KALMAN_FILTER_ASSERT_SVH
`define ANGLE_BIAS_KALMAN_FILTER_ASSERT_SVH

// Antecedent in one cycle, consequent in the next one, ignored during reset.
`define ABKF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kalman filter check failed");

// Antecedent and consequent in the same cycle, ignored during reset.
`define ABKF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kalman filter check failed");

// Next-cycle check that also holds while reset is applied.
`define ABKF_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("kalman filter reset check failed");

`endif

// ----- rtl/abkf_pkg.sv -----
// Shared types, register codes and the operation sequence of the Kalman filter.
// Used by abkf_alu and angle_bias_kalman_filter; depends on nothing else.
package abkf_pkg;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SUBADD,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef enum logic [4:0] {
        R_ANG, R_BIA, R_P00, R_P01, R_P10, R_P11,
        R_DT, R_QA, R_QB, R_RN, R_MEAS, R_RATE,
        R_S, R_K0, R_K1, R_Y, R_T0, R_T1, R_T2, R_T3
    } reg_id_t;

    localparam int NUM_REGS = 20;

    typedef struct packed {
        alu_op_t op;
        reg_id_t a;
        reg_id_t b;
        reg_id_t c;
        reg_id_t dst;
    } uop_t;

    localparam int          NUM_UOPS = 28;
    localparam logic [4:0]  LAST_UOP = 5'(NUM_UOPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_FETCH_C,
        ST_EXEC,
        ST_WAIT,
        ST_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        CFG_STEP_TIME,
        CFG_ANGLE_NOISE,
        CFG_BIAS_NOISE,
        CFG_MEAS_NOISE
    } cfg_idx_t;

    localparam logic [30:0] STEP_TIME_RST   = 31'd1677722;
    localparam logic [30:0] ANGLE_NOISE_RST = 31'd16777;
    localparam logic [30:0] BIAS_NOISE_RST  = 31'd50332;
    localparam logic [30:0] MEAS_NOISE_RST  = 31'd503316;

    // Predict, gain, correct and covariance update as a list of shared-unit steps.
    // The four covariance products are formed before any covariance entry changes.
    function automatic uop_t uop_at(input logic [4:0] pc);
        uop_t u;
        u = '{ALU_ADD, R_T0, R_T0, R_T0, R_T0};
        case (pc)
            5'd0:  u = '{ALU_SUB,    R_RATE, R_BIA, R_T0, R_T0};
            5'd1:  u = '{ALU_MUL,    R_DT,   R_T0,  R_T0, R_T0};
            5'd2:  u = '{ALU_ADD,    R_ANG,  R_T0,  R_T0, R_ANG};
            5'd3:  u = '{ALU_ADD,    R_P10,  R_P01, R_T0, R_T0};
            5'd4:  u = '{ALU_MUL,    R_DT,   R_T0,  R_T0, R_T0};
            5'd5:  u = '{ALU_MUL,    R_QA,   R_DT,  R_T0, R_T1};
            5'd6:  u = '{ALU_SUBADD, R_P00,  R_T0,  R_T1, R_P00};
            5'd7:  u = '{ALU_MUL,    R_DT,   R_P11, R_T0, R_T0};
            5'd8:  u = '{ALU_SUB,    R_P01,  R_T0,  R_T0, R_P01};
            5'd9:  u = '{ALU_SUB,    R_P10,  R_T0,  R_T0, R_P10};
            5'd10: u = '{ALU_MUL,    R_QB,   R_DT,  R_T0, R_T0};
            5'd11: u = '{ALU_ADD,    R_P11,  R_T0,  R_T0, R_P11};
            5'd12: u = '{ALU_ADD,    R_P00,  R_RN,  R_T0, R_S};
            5'd13: u = '{ALU_DIV,    R_P00,  R_S,   R_T0, R_K0};
            5'd14: u = '{ALU_DIV,    R_P10,  R_S,   R_T0, R_K1};
            5'd15: u = '{ALU_SUB,    R_MEAS, R_ANG, R_T0, R_Y};
            5'd16: u = '{ALU_MUL,    R_K0,   R_Y,   R_T0, R_T0};
            5'd17: u = '{ALU_ADD,    R_ANG,  R_T0,  R_T0, R_ANG};
            5'd18: u = '{ALU_MUL,    R_K1,   R_Y,   R_T0, R_T0};
            5'd19: u = '{ALU_ADD,    R_BIA,  R_T0,  R_T0, R_BIA};
            5'd20: u = '{ALU_MUL,    R_K0,   R_P00, R_T0, R_T0};
            5'd21: u = '{ALU_MUL,    R_K0,   R_P01, R_T0, R_T1};
            5'd22: u = '{ALU_MUL,    R_K1,   R_P00, R_T0, R_T2};
            5'd23: u = '{ALU_MUL,    R_K1,   R_P01, R_T0, R_T3};
            5'd24: u = '{ALU_SUB,    R_P00,  R_T0,  R_T0, R_P00};
            5'd25: u = '{ALU_SUB,    R_P01,  R_T1,  R_T0, R_P01};
            5'd26: u = '{ALU_SUB,    R_P10,  R_T2,  R_T0, R_P10};
            5'd27: u = '{ALU_SUB,    R_P11,  R_T3,  R_T0, R_P11};
            default: u = '{ALU_ADD, R_T0, R_T0, R_T0, R_T0};
        endcase
        return u;
    endfunction

endpackage

// ----- rtl/angle_bias_kalman_filter.sv -----
// Top level of the two-state angle and gyro bias Kalman filter, one state set per axis.
// Depends on abkf_pkg and abkf_alu.
//
//  Channel   Direction  Handshake          Payload
//  cfg       in         cfg_wr_en          cfg_index, cfg_data (31 bits)
//  s_        in         s_tvalid/s_tready  tuser: axis; tdata: angle, rate
//  m_        out        m_tvalid/m_tready  tuser: axis; tdata: angle, bias
//
// Each item runs 28 steps on the single shared unit, 11 multiplies and 2 divides
// among them; a new item is taken only once the last one is finished.
// Synchronous active-low reset restores the config registers and clears all states.
// A result waits in the output register while a new item is taken; an item finished
// before that result is taken waits until the output register is free.
module angle_bias_kalman_filter #(
    parameter int NUM_AXES  = 2,
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // measured_angle [31:0], gyro_rate [63:32]
    input  logic [0:0]  s_tuser,   // axis_select [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // filtered_angle [31:0], bias_estimate [63:32]
    output logic [0:0]  m_tuser    // axis_out [0]
);
    import abkf_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int XW   = (W > 32) ? W : 32;
    localparam int AX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam logic signed [XW-1:0] XMAX = XW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [XW-1:0] XMIN = -XMAX - XW'(1);
    localparam logic signed [XW-1:0] OMAX = XW'(64'sd2147483647);
    localparam logic signed [XW-1:0] OMIN = -OMAX - XW'(1);

    function automatic logic signed [W-1:0] sat_word(input logic signed [XW-1:0] v);
        logic signed [W-1:0] r;
        if (v > XMAX) begin
            r = W'(XMAX);
        end else if (v < XMIN) begin
            r = W'(XMIN);
        end else begin
            r = W'(v);
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_out(input logic signed [W-1:0] v);
        logic signed [XW-1:0] e;
        logic [31:0]          r;
        e = XW'(v);
        if (e > OMAX) begin
            r = 32'(OMAX);
        end else if (e < OMIN) begin
            r = 32'(OMIN);
        end else begin
            r = 32'(e);
        end
        return r;
    endfunction

    seq_state_t state_reg, state_next;
    logic [4:0] pc_reg, pc_next;
    uop_t       uop;

    logic [30:0] dt_reg, qa_reg, qb_reg, rn_reg;

    logic signed [W-1:0] rf_reg [NUM_REGS];
    logic signed [W-1:0] ang_st_reg [NUM_AXES];
    logic signed [W-1:0] bia_st_reg [NUM_AXES];
    logic signed [W-1:0] p00_st_reg [NUM_AXES];
    logic signed [W-1:0] p01_st_reg [NUM_AXES];
    logic signed [W-1:0] p10_st_reg [NUM_AXES];
    logic signed [W-1:0] p11_st_reg [NUM_AXES];

    logic [AX_W-1:0]     ax_reg, ax_in;
    logic signed [W-1:0] opa_reg, opb_reg, opc_reg;
    reg_id_t             rd_addr;
    logic signed [W-1:0] rd_data;

    alu_req_t            alu_req;
    logic                alu_done;
    logic signed [W-1:0] alu_result;

    logic        m_tvalid_reg;
    logic [0:0]  m_tuser_reg;
    logic [63:0] m_tdata_reg;

    logic accept_in, out_free;

    assign uop       = uop_at(pc_reg);
    assign accept_in = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign ax_in     = (NUM_AXES == 1) ? '0 : AX_W'(s_tuser);
    assign rd_data   = rf_reg[rd_addr];

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_FETCH_A;
            ST_FETCH_A: state_next = ST_FETCH_B;
            ST_FETCH_B: state_next = ST_FETCH_C;
            ST_FETCH_C: state_next = ST_EXEC;
            ST_EXEC:    state_next = ST_WAIT;
            ST_WAIT: begin
                if (alu_done) begin
                    state_next = (pc_reg == LAST_UOP) ? ST_DONE : ST_FETCH_A;
                end
            end
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready      = 1'b0;
        alu_req.start = 1'b0;
        alu_req.op    = uop.op;
        rd_addr       = uop.a;
        case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_FETCH_A: rd_addr = uop.a;
            ST_FETCH_B: rd_addr = uop.b;
            ST_FETCH_C: rd_addr = uop.c;
            ST_EXEC:    alu_req.start = 1'b1;
            default:    rd_addr = uop.a;
        endcase
    end

    abkf_alu #(
        .WORD_BITS(WORD_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (opa_reg),
        .b       (opb_reg),
        .c       (opc_reg),
        .done    (alu_done),
        .result  (alu_result)
    );

    assign pc_next = (state_reg == ST_IDLE) ? 5'd0 :
                     (state_reg == ST_WAIT && alu_done) ? pc_reg + 5'd1 : pc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pc_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            dt_reg       <= STEP_TIME_RST;
            qa_reg       <= ANGLE_NOISE_RST;
            qb_reg       <= BIAS_NOISE_RST;
            rn_reg       <= MEAS_NOISE_RST;
            for (int i = 0; i < NUM_AXES; i++) begin
                ang_st_reg[i] <= '0;
                bia_st_reg[i] <= '0;
                p00_st_reg[i] <= '0;
                p01_st_reg[i] <= '0;
                p10_st_reg[i] <= '0;
                p11_st_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_STEP_TIME:   dt_reg <= cfg_data;
                    CFG_ANGLE_NOISE: qa_reg <= cfg_data;
                    CFG_BIAS_NOISE:  qb_reg <= cfg_data;
                    CFG_MEAS_NOISE:  rn_reg <= cfg_data;
                    default:         dt_reg <= dt_reg;
                endcase
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == ST_DONE && out_free) begin
                ang_st_reg[ax_reg] <= rf_reg[R_ANG];
                bia_st_reg[ax_reg] <= rf_reg[R_BIA];
                p00_st_reg[ax_reg] <= rf_reg[R_P00];
                p01_st_reg[ax_reg] <= rf_reg[R_P01];
                p10_st_reg[ax_reg] <= rf_reg[R_P10];
                p11_st_reg[ax_reg] <= rf_reg[R_P11];
            end
        end
    end

    // Working registers, operand latches and the output payload.
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            ax_reg         <= ax_in;
            rf_reg[R_ANG]  <= ang_st_reg[ax_in];
            rf_reg[R_BIA]  <= bia_st_reg[ax_in];
            rf_reg[R_P00]  <= p00_st_reg[ax_in];
            rf_reg[R_P01]  <= p01_st_reg[ax_in];
            rf_reg[R_P10]  <= p10_st_reg[ax_in];
            rf_reg[R_P11]  <= p11_st_reg[ax_in];
            rf_reg[R_DT]   <= sat_word(XW'({1'b0, dt_reg}));
            rf_reg[R_QA]   <= sat_word(XW'({1'b0, qa_reg}));
            rf_reg[R_QB]   <= sat_word(XW'({1'b0, qb_reg}));
            rf_reg[R_RN]   <= sat_word(XW'({1'b0, rn_reg}));
            rf_reg[R_MEAS] <= sat_word(XW'($signed(s_tdata[31:0])));
            rf_reg[R_RATE] <= sat_word(XW'($signed(s_tdata[63:32])));
        end else if (state_reg == ST_WAIT && alu_done) begin
            rf_reg[uop.dst] <= alu_result;
        end
        case (state_reg)
            ST_FETCH_A: opa_reg <= rd_data;
            ST_FETCH_B: opb_reg <= rd_data;
            ST_FETCH_C: opc_reg <= rd_data;
            default:    opa_reg <= opa_reg;
        endcase
        if (state_reg == ST_DONE && out_free) begin
            m_tuser_reg <= ax_reg[0];
            m_tdata_reg <= {sat_out(rf_reg[R_BIA]), sat_out(rf_reg[R_ANG])};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/abkf_alu.sv -----
// Shared arithmetic unit: saturating add and subtract, shift-add multiply and
// restoring divide in signed fixed point. Depends on abkf_pkg.
module abkf_alu #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  abkf_pkg::alu_req_t          req,
    input  logic signed [WORD_BITS-1:0] a,
    input  logic signed [WORD_BITS-1:0] b,
    input  logic signed [WORD_BITS-1:0] c,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] result
);
    import abkf_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int QW = W + F;
    localparam int PW = 2 * W;
    localparam int MW = PW + 1 - F;
    localparam int CW = $clog2(QW + 1);
    localparam logic signed [W-1:0]   WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]   WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [PW:0]           RND  = (PW+1)'(1) << (F - 1);

    typedef enum logic [1:0] {AL_IDLE, AL_MUL, AL_DIV, AL_FIN} alu_state_t;

    alu_state_t          st_reg, st_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    alu_op_t             op_reg, op_next;
    logic                neg_reg, neg_next;
    logic [W-1:0]        x_reg, x_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [QW-1:0]       quo_reg, quo_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic signed [W-1:0] res_reg, res_next;

    logic [W-1:0]        mag_a, mag_b;
    logic signed [W+1:0] sum;
    logic [W:0]          upper_sum;
    logic [W:0]          trial;
    logic                ge;
    logic [PW:0]         rounded;
    logic [MW-1:0]       mres;
    logic                over;
    logic [W-1:0]        mag_res;

    assign mag_a = a[W-1] ? (W'(~a) + W'(1)) : W'(a);
    assign mag_b = b[W-1] ? (W'(~b) + W'(1)) : W'(b);

    always_comb begin
        case (req.op)
            ALU_ADD:    sum = (W+2)'(a) + (W+2)'(b);
            ALU_SUB:    sum = (W+2)'(a) - (W+2)'(b);
            ALU_SUBADD: sum = (W+2)'(a) - (W+2)'(b) + (W+2)'(c);
            default:    sum = '0;
        endcase
    end

    assign upper_sum = {1'b0, prod_reg[PW-1:W]} + (prod_reg[0] ? {1'b0, x_reg} : '0);
    assign trial     = {rem_reg, quo_reg[QW-1]};
    assign ge        = trial >= {1'b0, x_reg};
    assign rounded   = {1'b0, prod_reg} + RND;
    assign mres      = rounded[PW:F];

    always_comb begin
        if (op_reg == ALU_MUL) begin
            over    = (mres >> (W - 1)) != '0;
            mag_res = W'(mres);
        end else begin
            over    = (quo_reg >> (W - 1)) != '0;
            mag_res = W'(quo_reg);
        end
    end

    always_comb begin
        st_next   = st_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        neg_next  = neg_reg;
        x_next    = x_reg;
        prod_next = prod_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        case (st_reg)
            AL_IDLE: begin
                if (req.start) begin
                    op_next  = req.op;
                    neg_next = a[W-1] ^ b[W-1];
                    cnt_next = '0;
                    case (req.op)
                        ALU_MUL: begin
                            x_next    = mag_a;
                            prod_next = {W'(0), mag_b};
                            st_next   = AL_MUL;
                        end
                        ALU_DIV: begin
                            if (mag_b == '0) begin
                                res_next  = '0;
                                done_next = 1'b1;
                            end else begin
                                x_next   = mag_b;
                                quo_next = {mag_a, F'(0)};
                                rem_next = '0;
                                st_next  = AL_DIV;
                            end
                        end
                        default: begin
                            if (sum > (W+2)'(WMAX)) begin
                                res_next = WMAX;
                            end else if (sum < (W+2)'(WMIN)) begin
                                res_next = WMIN;
                            end else begin
                                res_next = W'(sum);
                            end
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            AL_MUL: begin
                prod_next = {upper_sum, prod_reg[W-1:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    st_next = AL_FIN;
                end
            end
            AL_DIV: begin
                rem_next = ge ? W'(trial - {1'b0, x_reg}) : W'(trial);
                quo_next = {quo_reg[QW-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1)) begin
                    st_next = AL_FIN;
                end
            end
            AL_FIN: begin
                if (over) begin
                    res_next = neg_reg ? WMIN : WMAX;
                end else begin
                    res_next = neg_reg ? -$signed(mag_res) : $signed(mag_res);
                end
                done_next = 1'b1;
                st_next   = AL_IDLE;
            end
            default: st_next = AL_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= AL_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        op_reg   <= op_next;
        neg_reg  <= neg_next;
        x_reg    <= x_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- rtl/abkf_checker.sv -----
// Port-level checks for the angle and bias Kalman filter, bound to its top level.
// Depends on angle_bias_kalman_filter_assert.svh.
`include "angle_bias_kalman_filter_assert.svh"

module abkf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // Once an item is taken the block is busy and drops s_tready.
    `ABKF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // A new result only appears at the end of work, never while idle.
    `ABKF_ASSERT_SAME(a_result_from_work, $rose(m_tvalid), !$past(s_tready))

    // A stalled result keeps its value.
    `ABKF_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Reset leaves no result pending.
    `ABKF_ASSERT_RST(a_reset_clears, !aresetn, !m_tvalid)

endmodule

bind angle_bias_kalman_filter abkf_checker u_abkf_checker (.*);

// ----- test/tb_angle_bias_kalman_filter.sv -----
// Self-checking testbench for the angle and gyro bias Kalman filter.
// It predicts every result with its own fixed-point filter model and compares it field by field.
// It depends on abkf_pkg and the angle_bias_kalman_filter RTL.
module tb_angle_bias_kalman_filter;
    timeunit 1ns;
    timeprecision 1ps;
    import abkf_pkg::*;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int DRAIN_CYCLES = 700;

    typedef struct {
        logic        axis;
        logic [31:0] angle;
        logic [31:0] rate;
    } sample_t;

    typedef struct {
        logic        axis;
        logic [31:0] angle;
        logic [31:0] bias;
    } estimate_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    cfg_idx_t    cfg_index;
    logic [30:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;

    angle_bias_kalman_filter uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Filter model state and register copies.
    longint    dt, q_angle, q_bias, r_meas;
    longint    ang_st[2], bia_st[2], p00_st[2], p01_st[2], p10_st[2], p11_st[2];

    sample_t   pending_samples[$];
    estimate_t expected_estimates[$];
    int        failures;
    int        cycle_count;
    logic      in_taken;
    int        send_gap;
    int        ready_gap;
    int        hold_cycles;
    bit        hold_req;
    bit        sender_paused;

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic longint q_sat(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        longint unsigned x, y, p;
        bit neg;
        x = (a < 0) ? -a : a;
        y = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        p = (x * y + 64'd8388608) >> 24;
        if (p >= 64'd2147483648) return neg ? Q_MIN : Q_MAX;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint q_div(longint n, longint d);
        longint unsigned nm, dm, q;
        bit neg;
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        neg = (n < 0) != (d < 0);
        if (dm == 0) return 0;
        q = (nm << 24) / dm;
        if (q >= 64'd2147483648) return neg ? Q_MIN : Q_MAX;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic estimate_t kalman_update(sample_t smp);
        estimate_t est;
        int ax;
        longint meas, rate, ang, bia, p00, p01, p10, p11, s, k0, k1, y, o00, o01;
        ax = smp.axis;
        meas = longint'(signed'(smp.angle));
        rate = longint'(signed'(smp.rate));
        ang = ang_st[ax]; bia = bia_st[ax];
        p00 = p00_st[ax]; p01 = p01_st[ax]; p10 = p10_st[ax]; p11 = p11_st[ax];
        ang = q_sat(ang + q_mul(dt, q_sat(rate - bia)));
        p00 = q_sat(p00 - q_mul(dt, q_sat(p10 + p01)) + q_mul(q_angle, dt));
        p01 = q_sat(p01 - q_mul(dt, p11));
        p10 = q_sat(p10 - q_mul(dt, p11));
        p11 = q_sat(p11 + q_mul(q_bias, dt));
        s = q_sat(p00 + r_meas);
        if (s == 0) begin
            k0 = 0;
            k1 = 0;
        end else begin
            k0 = q_div(p00, s);
            k1 = q_div(p10, s);
        end
        y = q_sat(meas - ang);
        ang = q_sat(ang + q_mul(k0, y));
        bia = q_sat(bia + q_mul(k1, y));
        // The covariance update works from the values before it starts.
        o00 = p00;
        o01 = p01;
        p00 = q_sat(o00 - q_mul(k0, o00));
        p01 = q_sat(o01 - q_mul(k0, o01));
        p10 = q_sat(p10 - q_mul(k1, o00));
        p11 = q_sat(p11 - q_mul(k1, o01));
        ang_st[ax] = ang; bia_st[ax] = bia;
        p00_st[ax] = p00; p01_st[ax] = p01; p10_st[ax] = p10; p11_st[ax] = p11;
        est.axis = smp.axis;
        est.angle = ang[31:0];
        est.bias = bia[31:0];
        return est;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            3: return 32'($urandom_range(0, 2048)) - 32'd1024;
            default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
        endcase
    endfunction

    task automatic push_sample(logic axis, logic [31:0] angle, logic [31:0] rate);
        sample_t smp;
        smp.axis = axis;
        smp.angle = angle;
        smp.rate = rate;
        pending_samples.push_back(smp);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [30:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_STEP_TIME:   dt = longint'(value);
            CFG_ANGLE_NOISE: q_angle = longint'(value);
            CFG_BIAS_NOISE:  q_bias = longint'(value);
            default:         r_meas = longint'(value);
        endcase
    endtask

    task automatic write_all(logic [30:0] t, logic [30:0] qa, logic [30:0] qb, logic [30:0] rn);
        write_reg(CFG_STEP_TIME, t);
        write_reg(CFG_ANGLE_NOISE, qa);
        write_reg(CFG_BIAS_NOISE, qb);
        write_reg(CFG_MEAS_NOISE, rn);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (pending_samples.size() == 0 && expected_estimates.size() == 0 && !s_tvalid);
        repeat (20) @(negedge aclk);
    endtask

    // Sender: one item per handshake, random gaps between items.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            s_tvalid <= 1'b1;
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0 && !sender_paused) begin
            sample_t smp;
            smp = pending_samples.pop_front();
            s_tvalid <= 1'b1;
            s_tuser <= smp.axis;
            s_tdata <= {smp.rate, smp.angle};
            send_gap <= ($urandom_range(0, 31) == 0) ? $urandom_range(50, 400)
                                                     : $urandom_range(0, 3);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (hold_req && hold_cycles == 0) begin
            hold_cycles <= 5000;
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= (hold_cycles == 1);
        end else if (ready_gap > 0) begin
            ready_gap <= ready_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                ready_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(100, 600)
                                                          : $urandom_range(1, 4);
            end
        end
    end

    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready && aresetn;
        if (aresetn && s_tvalid && s_tready) begin
            sample_t smp;
            smp.axis = s_tuser[0];
            smp.angle = s_tdata[31:0];
            smp.rate = s_tdata[63:32];
            expected_estimates.push_back(kalman_update(smp));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            estimate_t est;
            if (expected_estimates.size() == 0) begin
                $error("unexpected item: axis_out %0d", m_tuser[0]);
                failures++;
            end else begin
                est = expected_estimates.pop_front();
                if (m_tuser[0] !== est.axis) begin
                    $error("axis_out: expected %0d, got %0d", est.axis, m_tuser[0]);
                    failures++;
                end
                if (m_tdata[31:0] !== est.angle) begin
                    $error("filtered_angle: expected %0d, got %0d",
                           signed'(est.angle), signed'(m_tdata[31:0]));
                    failures++;
                end
                if (m_tdata[63:32] !== est.bias) begin
                    $error("bias_estimate: expected %0d, got %0d",
                           signed'(est.bias), signed'(m_tdata[63:32]));
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int phase;
        int n;
        failures = 0;
        cycle_count = 0;
        in_taken = 1'b0;
        send_gap = 0;
        ready_gap = 0;
        hold_cycles = 0;
        hold_req = 1'b0;
        sender_paused = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_STEP_TIME;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        dt = longint'(STEP_TIME_RST);
        q_angle = longint'(ANGLE_NOISE_RST);
        q_bias = longint'(BIAS_NOISE_RST);
        r_meas = longint'(MEAS_NOISE_RST);
        for (int i = 0; i < 2; i++) begin
            ang_st[i] = 0; bia_st[i] = 0;
            p00_st[i] = 0; p01_st[i] = 0; p10_st[i] = 0; p11_st[i] = 0;
        end
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // With no angle noise and no measurement noise the divisor starts at zero.
        write_all(STEP_TIME_RST, 31'd0, BIAS_NOISE_RST, 31'd0);
        push_sample(1'b0, 32'h0100_0000, 32'h0000_0000);
        push_sample(1'b1, 32'hff00_0000, 32'h0080_0000);
        push_sample(1'b0, 32'h0000_0000, 32'h0000_0000);
        wait_idle();

        // Field extremes with the reset settings.
        write_all(STEP_TIME_RST, ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
        push_sample(1'b0, 32'h7fffffff, 32'h7fffffff);
        push_sample(1'b1, 32'h80000000, 32'h80000000);
        push_sample(1'b0, 32'h80000000, 32'h7fffffff);
        push_sample(1'b1, 32'h7fffffff, 32'h80000000);
        push_sample(1'b0, 32'h00000000, 32'hffffffff);
        push_sample(1'b1, 32'hffffffff, 32'h00000001);
        push_sample(1'b0, 32'h5555aaaa, 32'haaaa5555);
        push_sample(1'b1, 32'h00000000, 32'h00000000);
        wait_idle();

        // Largest step time and noise registers drive the estimates into saturation.
        write_all(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        push_sample(1'b0, 32'h0100_0000, 32'h0200_0000);
        push_sample(1'b1, 32'h80000000, 32'h7fffffff);
        push_sample(1'b0, 32'h7fffffff, 32'h80000000);
        push_sample(1'b1, 32'h0000_0000, 32'h0000_0000);
        wait_idle();

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_all(STEP_TIME_RST, ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
                1: write_all(31'd0, 31'd0, 31'd0, 31'd0);
                2: write_all(31'h7fffffff, 31'($urandom), 31'($urandom), 31'($urandom));
                default: write_all(31'($urandom_range(0, 32'h0100_0000)),
                                   31'($urandom_range(0, 32'h0040_0000)),
                                   31'($urandom_range(0, 32'h0040_0000)),
                                   31'($urandom_range(0, 32'h0100_0000)));
            endcase
            n = (phase == 1 || phase == 2) ? 150 : 375;
            for (int i = 0; i < n; i++) begin
                push_sample(1'($urandom), random_word(), random_word());
            end
            if (phase == 0) begin
                // Hold off the receiver long enough for the input to back up.
                @(posedge aclk);
                hold_req = 1'b1;
                @(posedge aclk);
                hold_req = 1'b0;
            end
            if (phase == 3) begin
                // Pause the sender midway until every outstanding result is back.
                wait (pending_samples.size() < n / 2);
                @(posedge aclk);
                sender_paused = 1'b1;
                wait (expected_estimates.size() == 0 && !s_tvalid);
                @(posedge aclk);
                sender_paused = 1'b0;
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
